[sv/lut_binary_coded_gemv_core_defines.svh]
// Assertion shorthands shared by the core's modules.
// Every property is sampled on i_clk and held off while i_rst_n is low.
`ifndef LUT_BINARY_CODED_GEMV_CORE_DEFINES_SVH
`define LUT_BINARY_CODED_GEMV_CORE_DEFINES_SVH

// Same-cycle implication.
`define LBCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBCG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lbcg_pkg.sv]
package lbcg_pkg;

    localparam int ACT_BITS       = 16;
    localparam int MAX_LENGTH_DEF = 256;
    localparam int CHUNK          = 8;
    localparam int LANES          = 4;
    localparam int WORD_ELEMS     = CHUNK * LANES;
    localparam int LOOK_W         = ACT_BITS + 4;
    localparam int PSUM_W         = 25;
    localparam int SCALE_W        = 16;
    localparam int BIAS_W         = 16;
    localparam int PROD_W         = SCALE_W + PSUM_W;
    localparam int RES_W          = 48;
    localparam int IDX_W          = 12;
    localparam int CNT_W          = 4;
    localparam int ROWS_W         = 13;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX   = 4'd8;
    localparam logic [ROWS_W-1:0] ROWS_MAX  = 13'd4096;
    localparam logic [CNT_W-1:0]  WPP_RST   = 4'd8;
    localparam logic [CNT_W-1:0]  NPL_RST   = 4'd4;
    localparam logic [ROWS_W-1:0] ROWS_RST  = 13'd1024;

    typedef enum logic [1:0] {
        REG_WPP  = 2'd0,
        REG_NPL  = 2'd1,
        REG_BIAS = 2'd2,
        REG_ROWS = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_WEIGHT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                      first_word;
        logic                      first_row;
        logic                      last_plane;
        logic                      emit;
        logic                      last_row;
        logic [IDX_W-1:0]          row_index;
        logic signed [SCALE_W-1:0] scale;
    } t_ctl;

    typedef struct packed {
        logic                    last_row;
        logic [IDX_W-1:0]        row_index;
        logic signed [RES_W-1:0] value;
    } t_res;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > CNT_MAX) begin
            r = CNT_MAX;
        end
        return r;
    endfunction

    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
        logic [ROWS_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 13'd1;
        end else if (v > ROWS_MAX) begin
            r = ROWS_MAX;
        end
        return r;
    endfunction

endpackage

[sv/lbcg_lane.sv]
module lbcg_lane
    import lbcg_pkg::*;
#(
    parameter int  MAX_LENGTH = MAX_LENGTH_DEF,
    localparam int ROWS       = MAX_LENGTH / WORD_ELEMS,
    localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_wr,
    input  logic [RW-1:0]              i_wr_row,
    input  logic [2:0]                 i_wr_elem,
    input  logic signed [ACT_BITS-1:0] i_wr_data,
    input  logic                       i_rd,
    input  logic [RW-1:0]              i_rd_row,
    input  logic [CHUNK-1:0]           i_sel,
    output logic signed [LOOK_W-1:0]   o_look
);

    logic signed [ACT_BITS-1:0] r_mem [ROWS][CHUNK];
    logic signed [ACT_BITS-1:0] r_q [CHUNK];
    logic [CHUNK-1:0]           r_bits;
    logic signed [LOOK_W-1:0]   r_look;
    logic signed [LOOK_W-1:0]   n_look;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_row][i_wr_elem] <= i_wr_data;
        end
        if (i_rd) begin
            r_q    <= r_mem[i_rd_row];
            r_bits <= i_sel;
        end
        if (i_en) begin
            r_look <= n_look;
        end
    end

    // set bit adds the element, clear bit subtracts it
    always_comb begin
        n_look = '0;
        for (int s = 0; s < CHUNK; s++) begin
            if (r_bits[s]) begin
                n_look = n_look + LOOK_W'(r_q[s]);
            end else begin
                n_look = n_look - LOOK_W'(r_q[s]);
            end
        end
    end

    assign o_look = r_look;

endmodule

[sv/lbcg_merge.sv]
`include "lut_binary_coded_gemv_core_defines.svh"

module lbcg_merge
    import lbcg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_ctl                     i_ctl,
    input  logic signed [LOOK_W-1:0] i_look [LANES],
    input  logic signed [RES_W-1:0]  i_bias_prod,
    output logic                     o_res_valid,
    output t_res                     o_res
);

    logic                      r_s3_valid;
    t_ctl                      r_s3_ctl;
    logic signed [RES_W-1:0]   r_s3_bias;
    logic signed [PSUM_W-1:0]  r_pacc;
    logic signed [PSUM_W-1:0]  n_pacc;

    logic                      r_s4_valid;
    t_ctl                      r_s4_ctl;
    logic signed [RES_W-1:0]   r_s4_bias;
    logic signed [PROD_W-1:0]  r_s4_prod;

    logic signed [RES_W-1:0]   r_racc;
    logic signed [RES_W-1:0]   n_racc;

    always_comb begin
        n_pacc = i_ctl.first_word ? '0 : r_pacc;
        for (int j = 0; j < LANES; j++) begin
            n_pacc = n_pacc + PSUM_W'(i_look[j]);
        end
    end

    // first word of a row seeds the row with the bias term
    always_comb begin
        n_racc = r_s4_ctl.first_row ? r_s4_bias : r_racc;
        if (r_s4_ctl.last_plane) begin
            n_racc = n_racc + RES_W'(r_s4_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_valid) begin
                r_pacc    <= n_pacc;
                r_s3_ctl  <= i_ctl;
                r_s3_bias <= i_bias_prod;
            end
            if (r_s3_valid) begin
                r_s4_prod <= PROD_W'($signed(r_s3_ctl.scale) * r_pacc);
                r_s4_ctl  <= r_s3_ctl;
                r_s4_bias <= r_s3_bias;
            end
            if (r_s4_valid) begin
                r_racc <= n_racc;
            end
        end
    end

    assign o_res_valid     = r_s4_valid & r_s4_ctl.emit;
    assign o_res.value     = n_racc;
    assign o_res.row_index = r_s4_ctl.row_index;
    assign o_res.last_row  = r_s4_ctl.last_row;

    `LBCG_ASSERT_IMP(a_emit_on_plane_end, r_s4_valid && r_s4_ctl.emit,
        r_s4_ctl.last_plane, "row result emitted off a plane boundary")

endmodule

[sv/lut_binary_coded_gemv_core.sv]
// Binary-coded quantized matrix-vector core. Load the vector first, one activation
// per item (tuser 0); then stream weight words (tuser 1) row by row and plane by
// plane, words_per_plane words per plane. Each byte of a word drives one of four
// lanes that adds or subtracts eight stored activations; a merge stage sums the
// lanes into the plane, scales it by the plane's alpha and adds it to the row, and
// the row's last word yields one result in the activation-times-alpha scale. The
// core takes one item per cycle unless stalled; a row's result passes bank read,
// lane add, plane merge, alpha multiply and row add into the output register.
// The output register plus one skid entry buffer results; input stalls only
// while both hold results. Write configuration only while the core is idle.
`include "lut_binary_coded_gemv_core_defines.svh"

module lut_binary_coded_gemv_core
    import lbcg_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // act_value[15:0], weight_word[47:16],
                                         // plane_scale[63:48], row_bias[79:64]
    input  logic              s_tuser,   // cmd

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // row_result[47:0], row_index[59:48], zero
    output logic              m_tlast,   // last_row

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ROWS = MAX_LENGTH / WORD_ELEMS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = $clog2(MAX_LENGTH);
    localparam int ASW  = ACT_BITS + PW;
    localparam logic [2:0] WC_MASK = (ROWS >= 8) ? 3'd7 : 3'(ROWS - 1);

    // configuration
    logic [CNT_W-1:0]  r_wpp;
    logic [CNT_W-1:0]  r_npl;
    logic              r_bias_en;
    logic [ROWS_W-1:0] r_rows;
    logic              w_cfg_wr;
    t_reg_idx          w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpp     <= WPP_RST;
            r_npl     <= NPL_RST;
            r_bias_en <= 1'b0;
            r_rows    <= ROWS_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_WPP:  r_wpp     <= pwdata[CNT_W-1:0];
                REG_NPL:  r_npl     <= pwdata[CNT_W-1:0];
                REG_BIAS: r_bias_en <= pwdata[0];
                REG_ROWS: r_rows    <= pwdata[ROWS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_WPP:  prdata = APB_DW'(r_wpp);
            REG_NPL:  prdata = APB_DW'(r_npl);
            REG_BIAS: prdata = APB_DW'(r_bias_en);
            REG_ROWS: prdata = APB_DW'(r_rows);
            default:  prdata = '0;
        endcase
    end

    // input fields
    logic signed [ACT_BITS-1:0] w_act;
    logic [31:0]                w_word;
    logic signed [SCALE_W-1:0]  w_scale;
    logic signed [BIAS_W-1:0]   w_bias;

    assign w_act   = s_tdata[15:0];
    assign w_word  = s_tdata[47:16];
    assign w_scale = s_tdata[63:48];
    assign w_bias  = s_tdata[79:64];

    // handshake
    logic r_skid_valid;
    logic w_pipe_en;
    logic w_acc;
    logic w_acc_load;
    logic w_acc_weight;

    assign w_pipe_en    = !r_skid_valid;
    assign s_tready     = w_pipe_en;
    assign w_acc        = s_tvalid & s_tready;
    assign w_acc_load   = w_acc & (t_cmd'(s_tuser) == CMD_LOAD);
    assign w_acc_weight = w_acc & (t_cmd'(s_tuser) == CMD_WEIGHT);

    // sequencing counters
    logic [PW-1:0]         r_load_ptr;
    logic signed [ASW-1:0] r_act_sum;
    logic signed [ASW-1:0] w_act_ext;
    logic [2:0]            r_wc;
    logic [2:0]            r_pc;
    logic [IDX_W-1:0]      r_row_cnt;
    logic [CNT_W-1:0]      w_wpp;
    logic [CNT_W-1:0]      w_npl;
    logic [ROWS_W-1:0]     w_rows_m1;
    logic [ROWS_W-1:0]     w_rc_ext;
    logic                  w_wc_last;
    logic                  w_pc_last;
    logic                  w_row_end;
    logic                  w_last_row;

    assign w_act_ext  = ASW'(w_act);
    assign w_wpp      = clamp_cnt(r_wpp);
    assign w_npl      = clamp_cnt(r_npl);
    assign w_rows_m1  = clamp_rows(r_rows) - 13'd1;
    assign w_rc_ext   = ROWS_W'(r_row_cnt);
    assign w_wc_last  = (CNT_W'(r_wc) + 4'd1) >= w_wpp;
    assign w_pc_last  = (CNT_W'(r_pc) + 4'd1) >= w_npl;
    assign w_row_end  = w_wc_last & w_pc_last;
    assign w_last_row = w_rc_ext == w_rows_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr <= '0;
            r_act_sum  <= '0;
            r_wc       <= '0;
            r_pc       <= '0;
            r_row_cnt  <= '0;
        end else if (w_acc_load) begin
            r_load_ptr <= r_load_ptr + 1'b1;
            // pointer at zero starts a new vector
            r_act_sum  <= (r_load_ptr == '0) ? w_act_ext : r_act_sum + w_act_ext;
        end else if (w_acc_weight) begin
            r_load_ptr <= '0;
            if (w_wc_last) begin
                r_wc <= '0;
                r_pc <= w_pc_last ? 3'd0 : r_pc + 3'd1;
            end else begin
                r_wc <= r_wc + 3'd1;
            end
            if (w_row_end) begin
                r_row_cnt <= (w_rc_ext >= w_rows_m1) ? '0 : r_row_cnt + 1'b1;
            end
        end
    end

    // lanes: lane j holds elements 8*j..8*j+7 of every 32-element word slot
    logic [RW-1:0]            w_wr_row;
    logic [RW-1:0]            w_rd_row;
    logic signed [LOOK_W-1:0] w_look [LANES];

    assign w_wr_row = RW'(r_load_ptr >> 5);
    assign w_rd_row = RW'(r_wc & WC_MASK);

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        lbcg_lane #(
            .MAX_LENGTH (MAX_LENGTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_pipe_en),
            .i_wr      (w_acc_load && (r_load_ptr[4:3] == 2'(j))),
            .i_wr_row  (w_wr_row),
            .i_wr_elem (r_load_ptr[2:0]),
            .i_wr_data (w_act),
            .i_rd      (w_acc_weight),
            .i_rd_row  (w_rd_row),
            .i_sel     (w_word[8*j +: 8]),
            .o_look    (w_look[j])
        );
    end

    // control travels alongside the lane pipeline
    logic                      r_s1_valid;
    t_ctl                      r_s1_ctl;
    logic signed [BIAS_W-1:0]  r_s1_bias;
    logic signed [ASW-1:0]     r_s1_asum;
    logic                      r_s2_valid;
    t_ctl                      r_s2_ctl;
    logic signed [RES_W-1:0]   r_s2_bias_prod;
    t_ctl                      w_ctl;

    assign w_ctl.first_word = r_wc == '0;
    assign w_ctl.first_row  = (r_wc == '0) && (r_pc == '0);
    assign w_ctl.last_plane = w_wc_last;
    assign w_ctl.emit       = w_row_end;
    assign w_ctl.last_row   = w_last_row;
    assign w_ctl.row_index  = r_row_cnt;
    assign w_ctl.scale      = w_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_pipe_en) begin
            r_s1_valid <= w_acc_weight;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_weight) begin
            r_s1_ctl  <= w_ctl;
            r_s1_bias <= r_bias_en ? w_bias : '0;
            r_s1_asum <= r_act_sum;
        end
        if (w_pipe_en && r_s1_valid) begin
            r_s2_ctl       <= r_s1_ctl;
            r_s2_bias_prod <= RES_W'(r_s1_bias * r_s1_asum);
        end
    end

    logic w_res_valid;
    t_res w_res;

    lbcg_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_pipe_en),
        .i_valid     (r_s2_valid),
        .i_ctl       (r_s2_ctl),
        .i_look      (w_look),
        .i_bias_prod (r_s2_bias_prod),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register with one skid entry behind it
    logic r_out_valid;
    t_res r_out;
    t_res r_skid;
    logic w_take;

    assign w_take = r_out_valid & m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_out.row_index, r_out.value};
    assign m_tlast  = r_out.last_row;

    `LBCG_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry held while output register empty")
    `LBCG_ASSERT_NXT(a_row_wrap, w_acc_weight && w_row_end && w_last_row,
        r_row_cnt == '0, "row counter failed to wrap after last row")
    `LBCG_ASSERT_NXT(a_vector_restart, w_acc_load && (r_load_ptr == '0),
        r_act_sum == $past(w_act_ext), "activation sum not restarted on new vector")

endmodule
